// File: hdl/vvi_pkg.sv
// Package for the velocity Verlet body integrator: payload structs, command
// codes, fixed-point constants and saturation helpers. No dependencies.
`default_nettype none
package vvi_pkg;

    localparam int FRAC_BITS = 24;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int NUM_W     = 128;
    localparam int QCNT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_BODY = 8'd1;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_ADD_FORCE = 3'd1,
        CMD_CLR_FORCE = 3'd2,
        CMD_LOAD_POS  = 3'd3,
        CMD_LOAD_VEL  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] vec_x;
        logic signed [63:0] vec_y;
        logic signed [63:0] vec_z;
        logic [31:0]        time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POS,
        ST_DIV,
        ST_VEL,
        ST_OUT
    } state_t;

    // Lane control shared by the top level and each axis lane.
    typedef struct packed {
        logic start_mul;   // capture operands and begin the multiply steps
        logic start_div;   // begin the per-axis division
    } lane_ctl_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } lane_sts_t;

    // Saturate a 130-bit signed value to 64 bits.
    function automatic logic [63:0] sat64(input logic signed [129:0] v);
        logic [63:0] r;
        if (v > 130'sh0_7FFF_FFFF_FFFF_FFFF)
            r = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (v < -130'sh0_8000_0000_0000_0000)
            r = 64'h8000_0000_0000_0000;
        else
            r = v[63:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/velocity_verlet_body_integrator.sv
// Top level of the velocity Verlet integrator: channels, body state, command
// decode, and merging of the three axis lanes. Depends on vvi_pkg, vvi_lane.
// Usage:
// Items arrive on in_valid/in_ready as in_item_t; each transaction yields one
// out_item_t on out_valid/out_ready with the position and velocity after it.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data:
// index 0 is the mass, index 1 the static flag; other indexes are ignored.
// Writes are taken at any time and are meant to occur while the block idles.
// Non-tick commands and ticks on a static body pass from acceptance
// through the output state to the result. A tick on a moving body runs
// three axis lanes side by side: each lane first forms v*dt and a*dt*dt
// with a 32x32 multiplier over seven partial products, then divides its
// force by the mass in a restoring divider, one quotient bit per cycle
// over 128 bits, and finishes the velocity from two more partial products.
// One item is in flight at a time; in_ready is low until the result has
// left the output register, so the next item can be taken the cycle after.
// If the receiver stalls, the result holds in the output register and no
// new item is taken until it leaves.
// Reset clears position, velocity, acceleration and force to zero, sets the
// mass to one and the static flag to zero.
`default_nettype none
module velocity_verlet_body_integrator
    import vvi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    state_t state_reg, state_next;
    logic [62:0] mass_reg;
    logic        static_reg;
    logic [63:0] pos_reg [AXES];
    logic [63:0] vel_reg [AXES];
    logic [63:0] acc_reg [AXES];
    logic [63:0] frc_reg [AXES];
    logic [31:0] dt_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    lane_ctl_t   ctl;
    lane_sts_t   sts [AXES];
    logic [63:0] pos_new [AXES];
    logic [63:0] vel_new [AXES];
    logic [63:0] acc_new [AXES];
    logic        accept;
    logic        mul_done_all;
    logic        div_done_all;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The lanes run in lockstep; a phase ends once every lane reports done.
    assign mul_done_all = sts[0].mul_done && sts[1].mul_done && sts[2].mul_done;
    assign div_done_all = sts[0].div_done && sts[1].div_done && sts[2].div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= 63'd1;
            static_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BODY_MASS:   mass_reg   <= cfg_data[62:0];
                REG_STATIC_BODY: static_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (in_data.command == CMD_TICK && !static_reg)
                        state_next = ST_MUL;
                    else
                        state_next = ST_OUT;
                end
            ST_MUL:  state_next = ST_POS;
            ST_POS:  if (mul_done_all) state_next = ST_DIV;
            ST_DIV:  if (div_done_all) state_next = ST_OUT;
            ST_VEL:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Lane control outputs.
    always_comb
    begin
        ctl.start_mul = (state_reg == ST_MUL);
        ctl.start_div = (state_reg == ST_POS) && mul_done_all;
    end

    genvar k;
    generate
        for (k = 0; k < AXES; k++)
        begin : g_lane
            vvi_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .pos      (pos_reg[k]),
                .vel      (vel_reg[k]),
                .acc      (acc_reg[k]),
                .force_in (frc_reg[k]),
                .mass     (mass_reg),
                .dt       (dt_reg),
                .sts      (sts[k]),
                .pos_new  (pos_new[k]),
                .vel_new  (vel_new[k]),
                .acc_new  (acc_new[k])
            );
        end
    endgenerate

    logic [63:0] in_vec [AXES];
    assign in_vec[0] = in_data.vec_x;
    assign in_vec[1] = in_data.vec_y;
    assign in_vec[2] = in_data.vec_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dt_reg        <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
                frc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            if (accept)
            begin
                dt_reg <= in_data.time_step;
                for (int i = 0; i < AXES; i++)
                begin
                    case (in_data.command)
                        CMD_ADD_FORCE: frc_reg[i] <= sat64(
                            $signed({{66{frc_reg[i][63]}}, frc_reg[i]})
                            + $signed({{66{in_vec[i][63]}}, in_vec[i]}));
                        CMD_CLR_FORCE: frc_reg[i] <= '0;
                        CMD_LOAD_POS:  pos_reg[i] <= in_vec[i];
                        CMD_LOAD_VEL:  vel_reg[i] <= in_vec[i];
                        default:       ;
                    endcase
                end
            end
            // Merge: each lane result is taken once every lane is done.
            if (state_reg == ST_POS && mul_done_all)
                for (int i = 0; i < AXES; i++)
                    pos_reg[i] <= pos_new[i];
            if (state_reg == ST_DIV && div_done_all)
                for (int i = 0; i < AXES; i++)
                begin
                    vel_reg[i] <= vel_new[i];
                    acc_reg[i] <= acc_new[i];
                end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            out_reg.pos_x <= pos_reg[0];
            out_reg.pos_y <= pos_reg[1];
            out_reg.pos_z <= pos_reg[2];
            out_reg.vel_x <= vel_reg[0];
            out_reg.vel_y <= vel_reg[1];
            out_reg.vel_z <= vel_reg[2];
        end
    end

endmodule
`default_nettype wire

// File: hdl/vvi_lane.sv
// One axis lane: position update terms via a shared 32x32 multiplier stepped
// over partial products, restoring divider for force/mass, velocity update.
// Depends on vvi_pkg.
`default_nettype none
module vvi_lane
    import vvi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lane_ctl_t   ctl,
    input  wire logic [63:0] pos,
    input  wire logic [63:0] vel,
    input  wire logic [63:0] acc,
    input  wire logic [63:0] force_in,
    input  wire logic [62:0] mass,
    input  wire logic [31:0] dt,
    output lane_sts_t        sts,
    output logic [63:0]      pos_new,
    output logic [63:0]      vel_new,
    output logic [63:0]      acc_new
);

    // Multiply sequencer: products a*dt*dt (in two passes) and v*dt, done as
    // 32x32 partial products accumulated one per cycle.
    // Job 0: a*dt -> t (2 partials), job 1: v*dt (2 partials),
    // job 2: t(96b)*dt (3 partials). Magnitudes with sign applied at end.
    // Running a*dt first means t is registered before job 2 reads it, so the
    // seven steps issue back to back.
    logic [3:0]   mstep_reg, mstep_next;
    logic         mbusy_reg, mbusy_next;
    logic [127:0] macc_reg, macc_next;
    logic [127:0] vdt_reg, vdt_next;     // |v|*dt
    logic [127:0] adt_reg, adt_next;     // |a|*dt
    logic [31:0]  ma_reg;
    logic [31:0]  mb_reg;
    logic [63:0]  mprod_reg;
    logic [63:0]  vmag, amag;
    logic         vneg, aneg;

    assign vneg = vel[63];
    assign aneg = acc[63];
    assign vmag = vneg ? (64'd0 - vel) : vel;
    assign amag = aneg ? (64'd0 - acc) : acc;

    // Operand selection per step.
    logic [31:0] sel_a;
    logic [6:0]  sel_sh;
    always_comb
    begin
        sel_a  = '0;
        sel_sh = '0;
        case (mstep_reg)
            4'd0:    begin sel_a = amag[31:0];    sel_sh = 7'd0;  end
            4'd1:    begin sel_a = amag[63:32];   sel_sh = 7'd32; end
            4'd2:    begin sel_a = vmag[31:0];    sel_sh = 7'd0;  end
            4'd3:    begin sel_a = vmag[63:32];   sel_sh = 7'd32; end
            4'd4:    begin sel_a = adt_reg[31:0]; sel_sh = 7'd0;  end
            4'd5:    begin sel_a = adt_reg[63:32];sel_sh = 7'd32; end
            4'd6:    begin sel_a = adt_reg[95:64];sel_sh = 7'd64; end
            default: begin sel_a = '0;            sel_sh = 7'd0;  end
        endcase
    end

    // Pipeline: step s registers operands, step s+1 registers product,
    // step s+2 accumulates. Product shift tracked alongside.
    logic [6:0] sh_d1_reg, sh_d2_reg;
    logic [3:0] st_d1_reg, st_d2_reg;
    logic       v_d1_reg, v_d2_reg;

    always_ff @(posedge clk)
    begin
        ma_reg    <= sel_a;
        mb_reg    <= dt;
        mprod_reg <= ma_reg * mb_reg;
        sh_d1_reg <= sel_sh;
        sh_d2_reg <= sh_d1_reg;
        st_d1_reg <= mstep_reg;
        st_d2_reg <= st_d1_reg;
        macc_reg  <= macc_next;
        vdt_reg   <= vdt_next;
        adt_reg   <= adt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg <= '0;
            mbusy_reg <= 1'b0;
            v_d1_reg  <= 1'b0;
            v_d2_reg  <= 1'b0;
        end
        else
        begin
            mstep_reg <= mstep_next;
            mbusy_reg <= mbusy_next;
            v_d1_reg  <= mbusy_reg && (mstep_reg < 4'd7);
            v_d2_reg  <= v_d1_reg;
        end
    end

    logic [127:0] pterm;
    logic         job_end;
    assign pterm   = {64'd0, mprod_reg} << sh_d2_reg;
    assign job_end = (st_d2_reg == 4'd1) || (st_d2_reg == 4'd3) || (st_d2_reg == 4'd6);

    logic [127:0] acc_sum;
    assign acc_sum = macc_reg + pterm;

    always_comb
    begin
        mstep_next = mstep_reg;
        mbusy_next = mbusy_reg;
        macc_next  = macc_reg;
        vdt_next   = vdt_reg;
        adt_next   = adt_reg;
        if (ctl.start_mul)
        begin
            mstep_next = 4'd0;
            mbusy_next = 1'b1;
            macc_next  = '0;
        end
        else if (mbusy_reg)
        begin
            if (mstep_reg < 4'd7)
                mstep_next = mstep_reg + 4'd1;
            if (v_d2_reg)
            begin
                if (job_end)
                begin
                    macc_next = '0;
                    case (st_d2_reg)
                        4'd1:    adt_next = acc_sum;
                        4'd3:    vdt_next = acc_sum;
                        default: macc_next = acc_sum;
                    endcase
                    if (st_d2_reg == 4'd6)
                    begin
                        macc_next  = acc_sum;
                        mbusy_next = 1'b0;
                    end
                end
                else
                    macc_next = acc_sum;
            end
        end
    end

    // The last partial product is registered into macc_reg as mul_done_reg rises;
    // the new position is registered in the cycle after, as pos_done_reg marks it valid.
    logic mul_done_reg;
    logic pos_done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_done_reg <= 1'b0;
            pos_done_reg <= 1'b0;
        end
        else
        begin
            mul_done_reg <= mbusy_reg && v_d2_reg && (st_d2_reg == 4'd6);
            pos_done_reg <= mul_done_reg;
        end
    end

    // Position: sums of floor-shifted signed products.
    logic signed [129:0] vterm, aterm, psum;
    logic [127:0] vdt_s, adt2_s;
    assign vdt_s  = vneg ? (128'd0 - vdt_reg) : vdt_reg;
    assign adt2_s = aneg ? (128'd0 - macc_reg) : macc_reg;
    assign vterm  = $signed({{2{vdt_s[127]}}, vdt_s}) >>> FRAC_BITS;
    assign aterm  = $signed({{2{adt2_s[127]}}, adt2_s}) >>> (2*FRAC_BITS+1);
    assign psum   = $signed({{66{pos[63]}}, pos}) + vterm + aterm;

    logic [63:0] pos_new_reg;
    always_ff @(posedge clk)
    begin
        if (mul_done_reg)
            pos_new_reg <= sat64(psum);
    end
    assign pos_new = pos_new_reg;

    // Divider: restoring, one quotient bit per cycle over 128 bits.
    logic [127:0] num_reg, num_next;
    logic [127:0] q_reg, q_next;
    logic [63:0]  rem_reg, rem_next;
    logic [7:0]   dcnt_reg, dcnt_next;
    logic         dbusy_reg, dbusy_next;
    logic         dneg_reg, dneg_next;
    logic         ddone_reg, ddone_next;
    logic [63:0]  fmag;
    logic [64:0]  rsh;
    assign fmag = force_in[63] ? (64'd0 - force_in) : force_in;
    assign rsh  = {rem_reg, num_reg[127]};

    always_comb
    begin
        num_next   = num_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        dbusy_next = dbusy_reg;
        dneg_next  = dneg_reg;
        ddone_next = 1'b0;
        if (ctl.start_div)
        begin
            num_next   = {64'd0, fmag} << FRAC_BITS;
            q_next     = '0;
            rem_next   = '0;
            dcnt_next  = '0;
            dneg_next  = force_in[63];
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            num_next = num_reg << 1;
            if (rsh >= {2'b0, mass})
            begin
                rem_next = 64'(rsh - {2'b0, mass});
                q_next   = {q_reg[126:0], 1'b1};
            end
            else
            begin
                rem_next = rsh[63:0];
                q_next   = {q_reg[126:0], 1'b0};
            end
            dcnt_next = dcnt_reg + 8'd1;
            if (dcnt_reg == 8'd127)
            begin
                dbusy_next = 1'b0;
                ddone_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dneg_reg <= dneg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg  <= '0;
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end
        else
        begin
            dcnt_reg  <= dcnt_next;
            dbusy_reg <= dbusy_next;
            ddone_reg <= ddone_next;
        end
    end

    // Quotient to signed acceleration; zero force and zero mass handled.
    logic [63:0] anew;
    always_comb
    begin
        if (fmag == 64'd0)
            anew = '0;
        else if (mass == 63'd0)
            anew = dneg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else if (dneg_reg)
            anew = (q_reg[127:64] != 0 || q_reg[63:0] > 64'h8000_0000_0000_0000)
                   ? 64'h8000_0000_0000_0000 : (64'd0 - q_reg[63:0]);
        else
            anew = (q_reg[127:64] != 0 || q_reg[63:0] > 64'h7FFF_FFFF_FFFF_FFFF)
                   ? 64'h7FFF_FFFF_FFFF_FFFF : q_reg[63:0];
    end

    // Velocity: (a_old + a_new)*dt >> (FRAC_BITS+1). The 65x32 magnitude
    // product is built from a low 32x32 and a high 33x32 partial product.
    logic [64:0]  asum;
    logic         sneg;
    logic [64:0]  smag;
    logic [1:0]   vstep_reg;
    logic [97:0]  sprod_reg;
    logic [63:0]  acc_new_reg;
    logic [63:0]  vel_new_reg;
    logic         vdone_reg;
    logic [63:0]  vp_lo_reg;
    logic [63:0]  vp_hi_reg;
    assign asum = {acc[63], acc} + {anew[63], anew};
    assign sneg = asum[64];
    assign smag = sneg ? (65'd0 - asum) : asum;

    logic signed [129:0] vtrm, vsum;
    logic [127:0] sp_s;
    assign sp_s = sneg ? (128'd0 - {30'd0, sprod_reg}) : {30'd0, sprod_reg};
    assign vtrm = $signed({{2{sp_s[127]}}, sp_s}) >>> (FRAC_BITS+1);
    assign vsum = $signed({{66{vel[63]}}, vel}) + vtrm;

    always_ff @(posedge clk)
    begin
        if (ddone_reg)
            vp_lo_reg <= smag[31:0] * dt;
        if (vstep_reg == 2'd1)
            vp_hi_reg <= {31'd0, smag[64:32]} * {32'd0, dt};
        if (vstep_reg == 2'd2)
            sprod_reg <= {2'd0, vp_hi_reg, 32'd0} + {34'd0, vp_lo_reg};
        if (vstep_reg == 2'd3)
        begin
            acc_new_reg <= anew;
            vel_new_reg <= sat64(vsum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vstep_reg <= '0;
            vdone_reg <= 1'b0;
        end
        else
        begin
            vdone_reg <= (vstep_reg == 2'd3);
            if (ddone_reg)
                vstep_reg <= 2'd1;
            else if (vstep_reg != 2'd0)
                vstep_reg <= vstep_reg + 2'd1;
        end
    end

    assign acc_new      = acc_new_reg;
    assign vel_new      = vel_new_reg;
    assign sts.mul_done = pos_done_reg;
    assign sts.div_done = vdone_reg;

endmodule
`default_nettype wire
